// ----- src/sstk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sstk_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int COUNT_BITS = 32;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    // k runs 0..NUM_SLOTS
    localparam int K_W    = $clog2(NUM_SLOTS + 1);
    // rank arithmetic: holds rank_index + 1 and k with room to spare
    localparam int CMP_W  = K_W + 5;
    localparam int EQ_W   = (COUNT_BITS > CMP_W) ? COUNT_BITS : CMP_W;

    localparam logic [15:0]           EMPTY_ELEMENT = 16'h7FFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [15:0]           element;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] error;
    } sstk_entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_SWAP,
        OP_WRITE
    } store_op_t;

    typedef struct packed {
        store_op_t         op;
        logic [SLOT_W-1:0] addr;
        sstk_entry_t       wdata;
    } store_ctl_t;

    typedef struct packed {
        logic ahead;   // b ranks strictly ahead of a
        logic better;  // b is a strictly better eviction victim than a
        logic match;   // b holds the key
    } cmp_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_SORT,
        S_READ_IDX,
        S_READ_CMP,
        S_OUT
    } sstk_state_t;

endpackage

`default_nettype wire

// ----- src/space_saving_top_k_sketch_top.sv -----
// Space-Saving heavy-hitter sketch, one request at a time.
// Insert: accept, then slot scan (stops at first match, at most NUM_SLOTS slots), then write.
//   Insert of 32767 is dropped in the accept cycle.
// Query: bubble passes until one makes no swap (at most NUM_SLOTS passes, set by disorder), then
//   rank and compare slot reads, then the output register; the single rank comparator is shared.
// Reset: synchronous, active low; store cleared to 32767/0/0, outputs idle.
`timescale 1ns / 1ps
`default_nettype none

module space_saving_top_k_sketch_top import sstk_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input request
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] value, [19:16] rank_index, [23:20] zero
    input  wire logic        s_tuser,   // mode: 0 insert, 1 query
    // result request
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [15:0] result_element
    output      logic        m_tlast    // finished
);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    sstk_state_t           state_reg,    state_next;
    logic [SLOT_W-1:0]     step_reg,     step_next;
    logic                  swap_reg,     swap_next;
    logic                  found_reg,    found_next;
    logic                  oor_reg,      oor_next;
    logic [15:0]           value_reg,    value_next;
    logic [3:0]            idx_reg,      idx_next;
    sstk_entry_t           best_reg,     best_next;
    logic [SLOT_W-1:0]     best_idx_reg, best_idx_next;
    logic [COUNT_BITS-1:0] g_reg,        g_next;
    logic [COUNT_BITS-1:0] ccnt_reg,     ccnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           out_elem_reg,  out_elem_next;
    logic                  out_last_reg,  out_last_next;

    // ---------------------------------------------------------------
    // store and shared comparator
    // ---------------------------------------------------------------
    store_ctl_t        st_ctl;
    logic [SLOT_W-1:0] rd_addr;
    sstk_entry_t       st_head, st_next, st_rd;
    sstk_entry_t       cmp_a,   cmp_b;
    cmp_res_t          cmp_res;

    sstk_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (st_ctl),
        .rd_addr (rd_addr),
        .head    (st_head),
        .next    (st_next),
        .rd_data (st_rd)
    );

    sstk_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .key (value_reg),
        .res (cmp_res)
    );

    // sort compares neighbors at the head of the line; scan compares
    // the running victim against the slot being read
    always_comb begin
        if (state_reg == S_SORT) begin
            cmp_a = st_head;
            cmp_b = st_next;
        end else begin
            cmp_a = best_reg;
            cmp_b = st_rd;
        end
    end

    // ---------------------------------------------------------------
    // query rank arithmetic
    // ---------------------------------------------------------------
    logic              ordered;
    logic [16:0]       mag;
    logic [K_W-1:0]    k_val;
    logic [CMP_W-1:0]  idx_w, idx1, cmp_raw, cmp_c;
    logic              idx_oor, fin_rank, g_eq, pass;
    logic [SLOT_W-1:0] idx_slot, cmp_slot;
    logic              last_step;

    assign ordered  = value_reg[15];
    // -32768 becomes 32768 in 17 bits
    assign mag      = ordered ? (17'd0 - {value_reg[15], value_reg}) : {1'b0, value_reg};
    assign k_val    = (mag > 17'(NUM_SLOTS)) ? K_W'(NUM_SLOTS) : mag[K_W-1:0];
    assign idx_w    = CMP_W'(idx_reg);
    assign idx1     = idx_w + CMP_W'(1);
    assign idx_oor  = (idx_w >= CMP_W'(NUM_SLOTS));
    assign idx_slot = idx_w[SLOT_W-1:0];
    // idx >= k-1, also true for k of zero
    assign fin_rank = (idx1 >= CMP_W'(k_val));
    assign cmp_raw  = ordered ? idx1 : CMP_W'(k_val);
    assign cmp_c    = (cmp_raw > CMP_W'(NUM_SLOTS - 1)) ? CMP_W'(NUM_SLOTS - 1) : cmp_raw;
    assign cmp_slot = cmp_c[SLOT_W-1:0];
    assign g_eq     = (EQ_W'(g_reg) == EQ_W'(cmp_c));
    assign pass     = g_eq || ((best_reg.error == '0) ? (g_reg >= ccnt_reg)
                                                      : (g_reg >  ccnt_reg));
    assign last_step = (step_reg == SLOT_W'(NUM_SLOTS - 1));

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
    endfunction

    // ---------------------------------------------------------------
    // handshake
    // ---------------------------------------------------------------
    logic s_fire;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_elem_reg;
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        swap_next      = swap_reg;
        found_next     = found_reg;
        oor_next       = oor_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        g_next         = g_reg;
        ccnt_next      = ccnt_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        st_ctl.op    = OP_HOLD;
        st_ctl.addr  = best_idx_reg;
        st_ctl.wdata = best_reg;
        rd_addr      = step_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    value_next = s_tdata[15:0];
                    idx_next   = s_tdata[19:16];
                    step_next  = '0;
                    swap_next  = 1'b0;
                    found_next = 1'b0;
                    if (s_tuser) begin
                        state_next = S_SORT;
                    end else if (s_tdata[15:0] != EMPTY_ELEMENT) begin
                        state_next = S_SCAN;
                    end
                end
            end

            // one slot per cycle: first match wins, else track the victim
            S_SCAN: begin
                rd_addr = step_reg;
                if (cmp_res.match) begin
                    best_next     = st_rd;
                    best_idx_next = step_reg;
                    found_next    = 1'b1;
                    state_next    = S_UPDATE;
                end else begin
                    if ((step_reg == '0) || cmp_res.better) begin
                        best_next     = st_rd;
                        best_idx_next = step_reg;
                    end
                    if (last_step) begin
                        state_next = S_UPDATE;
                    end else begin
                        step_next = step_reg + SLOT_W'(1);
                    end
                end
            end

            S_UPDATE: begin
                st_ctl.op   = OP_WRITE;
                st_ctl.addr = best_idx_reg;
                if (found_reg) begin
                    st_ctl.wdata = '{element: best_reg.element,
                                     count:   sat_inc(best_reg.count),
                                     error:   best_reg.error};
                end else begin
                    st_ctl.wdata = '{element: value_reg,
                                     count:   sat_inc(best_reg.count),
                                     error:   best_reg.count};
                end
                state_next = S_IDLE;
            end

            // stable bubble pass over the rotating line; repeat until clean
            S_SORT: begin
                if (!last_step) begin
                    st_ctl.op = cmp_res.ahead ? OP_SWAP : OP_ROTATE;
                    swap_next = swap_reg || cmp_res.ahead;
                    step_next = step_reg + SLOT_W'(1);
                end else begin
                    st_ctl.op = OP_ROTATE;
                    step_next = '0;
                    swap_next = 1'b0;
                    if (!swap_reg) begin
                        state_next = S_READ_IDX;
                    end
                end
            end

            S_READ_IDX: begin
                rd_addr    = idx_slot;
                best_next  = st_rd;
                oor_next   = idx_oor;
                state_next = idx_oor ? S_OUT : S_READ_CMP;
            end

            S_READ_CMP: begin
                rd_addr    = cmp_slot;
                ccnt_next  = st_rd.count;
                g_next     = (best_reg.error > best_reg.count) ? '0
                                                               : best_reg.count - best_reg.error;
                state_next = S_OUT;
            end

            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    if (oor_reg) begin
                        out_elem_next = EMPTY_ELEMENT;
                        out_last_next = 1'b1;
                    end else begin
                        out_elem_next = pass ? best_reg.element : EMPTY_ELEMENT;
                        out_last_next = fin_rank || !pass;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            swap_reg      <= 1'b0;
            found_reg     <= 1'b0;
            oor_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            swap_reg      <= swap_next;
            found_reg     <= found_next;
            oor_reg       <= oor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        g_reg        <= g_next;
        ccnt_reg     <= ccnt_next;
        out_elem_reg <= out_elem_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

// ----- src/sstk_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sstk_cmp import sstk_pkg::*; (
    input  sstk_entry_t  a,
    input  sstk_entry_t  b,
    input  logic [15:0]  key,
    output cmp_res_t     res
);

    logic cnt_eq;
    logic err_eq;

    assign cnt_eq = (b.count == a.count);
    assign err_eq = (b.error == a.error);

    always_comb begin
        if (!cnt_eq) begin
            res.ahead = (b.count > a.count);
        end else if (!err_eq) begin
            res.ahead = (b.error < a.error);
        end else begin
            res.ahead = ($signed(b.element) > $signed(a.element));
        end

        res.better = (b.count < a.count) ||
                     (cnt_eq && (b.error > a.error)) ||
                     (cnt_eq && err_eq && ($signed(b.element) < $signed(a.element)));

        res.match = (b.element == key);
    end

endmodule

`default_nettype wire

// ----- src/sstk_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sstk_store import sstk_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  store_ctl_t        ctl,
    input  logic [SLOT_W-1:0] rd_addr,
    output sstk_entry_t       head,
    output sstk_entry_t       next,
    output sstk_entry_t       rd_data
);

    sstk_entry_t entry_reg  [NUM_SLOTS];
    sstk_entry_t entry_next [NUM_SLOTS];

    assign head    = entry_reg[0];
    assign next    = entry_reg[1];
    assign rd_data = entry_reg[rd_addr];

    // rotate: whole line moves toward slot 0, slot 0 wraps to the tail
    // swap:   slot 0 holds, slots 1.. move down, slot 1 wraps to the tail
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            entry_next[i] = entry_reg[i];
        end
        case (ctl.op)
            OP_ROTATE: begin
                for (int j = 0; j < NUM_SLOTS - 1; j++) begin
                    entry_next[j] = entry_reg[j+1];
                end
                entry_next[NUM_SLOTS-1] = entry_reg[0];
            end
            OP_SWAP: begin
                for (int j = 1; j < NUM_SLOTS - 1; j++) begin
                    entry_next[j] = entry_reg[j+1];
                end
                entry_next[NUM_SLOTS-1] = entry_reg[1];
            end
            OP_WRITE: begin
                entry_next[ctl.addr] = ctl.wdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                entry_reg[i] <= '{element: EMPTY_ELEMENT, count: '0, error: '0};
            end
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/sstk_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sstk_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // reset empties the result side
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a query keeps the block busy
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("ready right after a query");

    // a dropped insert leaves the block ready
    a_drop_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && (s_tdata[15:0] == 16'h7FFF) |=> s_tready)
        else $error("dropped insert stalled the block");

endmodule

bind space_saving_top_k_sketch_top sstk_checker u_sstk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
